[rtl/core/arp_cache_resolver_top_defines.svh]
// Assertion macros for the ARP cache resolver.
// Used by modules that carry concurrent checks.
`ifndef ARP_CACHE_RESOLVER_TOP_DEFINES_SVH
`define ARP_CACHE_RESOLVER_TOP_DEFINES_SVH
// Implication checked on every edge outside reset.
`define ACR_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define ACR_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/core/acr_pkg.sv]
// Package for the ARP cache resolver: types, codes and sizes.
// No dependencies.
package acr_pkg;
    localparam int TableEntries = 16;
    localparam int PendingLimit = 1024;
    localparam int SlotW = $clog2(TableEntries);
    localparam int QDepth = 2;
    localparam logic [47:0] BcastMac = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_ARP = 2'd0, CMD_RESOLVE = 2'd1, CMD_TICK = 2'd2, CMD_SCAN = 2'd3
    } t_cmd;
    typedef enum logic [2:0] {
        K_REPLY = 3'd0, K_REQUEST = 3'd1, K_FORWARD = 3'd2,
        K_HELD = 3'd3, K_DROPPED = 3'd4, K_RELEASE = 3'd5
    } t_kind;
    typedef enum logic [1:0] {
        CFG_LOCAL_IP = 2'd0, CFG_LOCAL_MAC = 2'd1, CFG_AGE_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] oper;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic [31:0] next_hop_ip;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [3:0]  slot;
        logic [10:0] held_count;
        logic        last;
    } t_out_word;
endpackage

[rtl/core/acr_front.sv]
// Front end: accepts input words, drops ARP packets not for this host,
// queues the rest for the back end. Depends on acr_pkg.
`include "arp_cache_resolver_top_defines.svh"
module acr_front import acr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_data,
    input  logic [31:0] i_local_ip,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_in_word o_q_data
);
    t_in_word r_q [QDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic acc, keep;

    assign o_stall = (r_cnt == 2'(QDepth));
    assign acc = i_valid && !o_stall;
    // ARP with a foreign target is silently dropped
    assign keep = !(t_cmd'(i_data.cmd) == CMD_ARP && i_data.target_ip != i_local_ip);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (acc && keep) r_wp <= r_wp + 1'b1;
            if (i_q_pop && o_q_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(acc && keep) - 2'(i_q_pop && o_q_valid);
        end
    end
    always_ff @(posedge i_clk) begin
        if (acc && keep) r_q[r_wp] <= i_data;
    end

    `ACR_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDepth), "queue overfull")
    `ACR_ASSERT_IMP(a_pop_ok, i_clk, i_rst_n, i_q_pop, o_q_valid, "pop of empty queue")
    `ACR_ASSERT_NXT(a_push, i_clk, i_rst_n, acc && keep && !i_q_pop, r_cnt != 2'd0,
        "push lost")
endmodule

[rtl/core/acr_back.sv]
// Back end: table, time, command sequencer and output register.
// Depends on acr_pkg.
`include "arp_cache_resolver_top_defines.svh"
module acr_back import acr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_in_word  i_q_data,
    input  logic [31:0] i_age_limit,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_REQ = 5'b00100,
        S_SCAN = 5'b01000, S_SREQ = 5'b10000
    } t_state;

    logic [31:0] r_addr  [TableEntries];
    logic [47:0] r_hw    [TableEntries];
    logic [31:0] r_stamp [TableEntries];
    logic [10:0] r_wait  [TableEntries];
    logic [TableEntries-1:0] r_used, r_res;
    logic [31:0] r_now;
    t_state r_st;
    t_in_word r_it;
    logic [SlotW-1:0] r_i;
    logic [SlotW-1:0] r_rs;      // slot for pending request
    logic [31:0] r_rip;
    t_out_word r_out;
    logic r_ov;

    // parallel lookup on the word at the queue head, registered in r_it
    logic [31:0] key;
    logic hit, free_ok;
    logic [SlotW-1:0] hit_s, free_s;
    always_comb begin
        key = (t_cmd'(r_it.cmd) == CMD_ARP) ? r_it.sender_ip : r_it.next_hop_ip;
        hit = 1'b0; hit_s = '0; free_ok = 1'b0; free_s = '0;
        for (int k = TableEntries-1; k >= 0; k--) begin
            if (r_used[k] && r_addr[k] == key) begin hit = 1'b1; hit_s = SlotW'(k); end
            if (!r_used[k]) begin free_ok = 1'b1; free_s = SlotW'(k); end
        end
    end

    logic out_free;
    assign out_free = !r_ov || !i_stall;
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;
    assign o_valid = r_ov;
    assign o_data = r_out;

    // scan helpers: last word when no later slot gives one, done when no used slot follows
    logic [31:0] age;
    logic last_i, done_i;
    logic [TableEntries-1:0] above, live, stay;
    always_comb begin
        age = r_now - r_stamp[r_i];
        for (int k = 0; k < TableEntries; k++) begin
            // silent eviction: resolved, nothing pending, aged out
            stay[k] = !r_res[k] || (r_wait[k] != 11'd0)
                || ((r_now - r_stamp[k]) <= i_age_limit);
            above[k] = (SlotW'(k) > r_i) && r_used[k];
            live[k] = above[k] && stay[k];
        end
        last_i = (live == '0);
        done_i = (above == '0);
    end

    function automatic t_out_word mk(t_kind k, logic [47:0] m, logic [31:0] ip,
                                     logic [SlotW-1:0] s, logic [10:0] h, logic l);
        t_out_word w;
        w.kind = k; w.peer_mac = m; w.peer_ip = ip; w.slot = 4'(s);
        w.held_count = h; w.last = l;
        return w;
    endfunction

    logic [SlotW-1:0] cs;
    always_comb cs = hit ? hit_s : free_s;

    always_ff @(posedge i_clk) begin
        logic ov_set;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_used <= '0; r_res <= '0; r_now <= '0;
            for (int k = 0; k < TableEntries; k++) r_wait[k] <= '0;
            r_i <= '0;
        end else begin
            ov_set = 1'b0;
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_it <= i_q_data; r_st <= S_EXEC;
                end
                S_EXEC: if (out_free) begin
                    case (t_cmd'(r_it.cmd))
                        CMD_ARP: begin
                            r_st <= S_IDLE;
                            if (hit || free_ok) begin
                                if (!hit) begin
                                    r_used[cs] <= 1'b1; r_addr[cs] <= r_it.sender_ip;
                                    r_wait[cs] <= '0;
                                end
                                r_hw[cs] <= r_it.sender_mac; r_res[cs] <= 1'b1;
                                r_stamp[cs] <= r_now;
                            end
                            if (r_it.oper == 16'd1) begin
                                ov_set = 1'b1;
                                r_out <= mk(K_REPLY, r_it.sender_mac, r_it.sender_ip,
                                    (hit || free_ok) ? cs : '0, 11'd0, 1'b1);
                            end
                        end
                        CMD_RESOLVE: begin
                            ov_set = 1'b1;
                            if (hit && r_res[hit_s]) begin
                                r_out <= mk(K_FORWARD, r_hw[hit_s], r_it.next_hop_ip,
                                    hit_s, 11'd0, 1'b1);
                                r_st <= S_IDLE;
                            end else if (!hit && !free_ok) begin
                                r_out <= mk(K_DROPPED, 48'd0, r_it.next_hop_ip, '0,
                                    11'd0, 1'b1);
                                r_st <= S_IDLE;
                            end else begin
                                if (!hit) begin
                                    r_used[cs] <= 1'b1; r_addr[cs] <= r_it.next_hop_ip;
                                    r_hw[cs] <= '0; r_stamp[cs] <= '0;
                                end
                                r_res[cs] <= 1'b0;
                                if (hit && r_wait[cs] >= 11'(PendingLimit)) begin
                                    r_out <= mk(K_DROPPED, 48'd0, r_it.next_hop_ip, cs,
                                        r_wait[cs], 1'b0);
                                end else begin
                                    r_wait[cs] <= (hit ? r_wait[cs] : 11'd0) + 11'd1;
                                    r_out <= mk(K_HELD, 48'd0, r_it.next_hop_ip, cs,
                                        (hit ? r_wait[cs] : 11'd0) + 11'd1, 1'b0);
                                end
                                r_rs <= cs; r_rip <= r_it.next_hop_ip; r_st <= S_REQ;
                            end
                        end
                        CMD_TICK: begin
                            r_now <= r_now + 32'd1; r_st <= S_IDLE;
                        end
                        default: begin r_i <= '0; r_st <= S_SCAN; end
                    endcase
                end
                S_REQ: if (out_free) begin
                    ov_set = 1'b1;
                    r_out <= mk(K_REQUEST, BcastMac, r_rip, r_rs, 11'd0, 1'b1);
                    r_st <= S_IDLE;
                end
                S_SCAN: if (out_free) begin
                    // one slot per visit; release may be followed by a request
                    if (!r_used[r_i]) begin
                        if (done_i) r_st <= S_IDLE;
                        else r_i <= r_i + 1'b1;
                    end else if (r_res[r_i] && r_wait[r_i] != 11'd0) begin
                        r_wait[r_i] <= '0; ov_set = 1'b1;
                        if (age > i_age_limit) begin
                            r_used[r_i] <= 1'b0; r_res[r_i] <= 1'b0;
                            r_out <= mk(K_RELEASE, r_hw[r_i], r_addr[r_i], r_i,
                                r_wait[r_i], last_i);
                            if (done_i) r_st <= S_IDLE; else r_i <= r_i + 1'b1;
                        end else begin
                            r_out <= mk(K_RELEASE, r_hw[r_i], r_addr[r_i], r_i,
                                r_wait[r_i], 1'b0);
                            r_st <= S_SREQ;
                        end
                    end else if (r_res[r_i] && age > i_age_limit) begin
                        r_used[r_i] <= 1'b0; r_res[r_i] <= 1'b0; r_wait[r_i] <= '0;
                        if (done_i) r_st <= S_IDLE;
                        else r_i <= r_i + 1'b1;
                    end else begin
                        ov_set = 1'b1;
                        r_out <= mk(K_REQUEST, BcastMac, r_addr[r_i], r_i, 11'd0, last_i);
                        if (done_i) r_st <= S_IDLE; else r_i <= r_i + 1'b1;
                    end
                end
                S_SREQ: if (out_free) begin
                    ov_set = 1'b1;
                    r_out <= mk(K_REQUEST, BcastMac, r_addr[r_i], r_i, 11'd0, last_i);
                    if (done_i) r_st <= S_IDLE; else begin r_i <= r_i + 1'b1; r_st <= S_SCAN; end
                end
                default: r_st <= S_IDLE;
            endcase
            r_ov <= ov_set || (r_ov && i_stall);
        end
    end

    `ACR_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_st), "state not one-hot")
    `ACR_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_st == S_IDLE, "pop while busy")
    `ACR_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ov && i_stall, $stable(r_out), "stalled word changed")
endmodule

[rtl/core/arp_cache_resolver_top.sv]
// ARP cache resolver top level: config registers, front and back ends.
// Depends on acr_pkg, acr_front, acr_back.
//
// Use: input words arrive on i_in_valid/o_in_stall; results leave on
// o_out_valid/i_out_stall, accepted where valid is high and stall low.
// Registers are written on i_cfg_valid && o_cfg_ready (always ready);
// the user must write them only while the block is idle, which the
// block itself does not enforce. No result carries local_mac (requests
// go to broadcast), so its writes are accepted and change nothing else.
// An accepted word is queued, popped into the back end once it is idle,
// and executed there into the result register; the back end takes no
// new word until it is idle again. A held packet, or one dropped at the
// pending limit, is followed by its request; a scan visits each slot up
// to the highest used slot, the back end's sequencer setting the order.
// The two-word queue lets the front accept while results wait.
// Reset clears valid, resolved and pending state and time; addresses,
// MACs and stamps are written before use. When the receiver stalls the
// result register holds, the sequencer waits, and the queue fills.
module arp_cache_resolver_top import acr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    logic [31:0] r_local_ip, r_age_limit;
    logic q_valid, q_pop;
    t_in_word q_data;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0; r_age_limit <= 32'd5000;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOCAL_IP:  r_local_ip <= i_cfg_data[31:0];
                CFG_LOCAL_MAC: ;
                CFG_AGE_LIMIT: r_age_limit <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    acr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid), .o_stall(o_in_stall),
        .i_data(i_in_data), .i_local_ip(r_local_ip),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );
    acr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_data(q_data), .i_age_limit(r_age_limit),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_data(o_out_data)
    );
endmodule

[verif/arp_cache_resolver_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for arp_cache_resolver_top: directed table, random traffic, flood.
// Depends on acr_pkg and the arp_cache_resolver_top RTL.
module arp_cache_resolver_top_tb;
    import acr_pkg::*;

    localparam int WatchdogLimit = 6000;
    localparam int DrainCycles = 60;
    localparam int HoldOffCycles = 500;
    localparam int FloodCount = 40;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [47:0] i_cfg_data;

    arp_cache_resolver_top DUT (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Shadow of the cache, advanced once per accepted input word
    logic [31:0] cfg_ip;
    logic [31:0] cfg_age;
    logic [31:0] ent_ip    [TableEntries];
    logic [47:0] ent_mac   [TableEntries];
    logic [31:0] ent_stamp [TableEntries];
    bit          ent_ok    [TableEntries];
    bit          ent_used  [TableEntries];
    int          ent_wait  [TableEntries];
    logic [31:0] now_ticks;

    t_out_word   due_words[$];   // results still owed by the block, oldest first
    int          err_cnt = 0;
    bit          quiet;          // no idling on either side while set
    bit          hold_req;       // asks the receiver for one long hold-off
    logic [31:0] ip_pool[24];

    function automatic int find_entry(logic [31:0] ip);
        for (int i = 0; i < TableEntries; i++)
            if (ent_used[i] && ent_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int claim_entry(logic [31:0] ip);
        int s;
        s = find_entry(ip);
        if (s >= 0) return s;
        for (int i = 0; i < TableEntries; i++) begin
            if (!ent_used[i]) begin
                ent_used[i] = 1; ent_ip[i] = ip; ent_ok[i] = 0;
                ent_wait[i] = 0; ent_mac[i] = '0; ent_stamp[i] = '0;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_out_word mk(t_kind k, logic [47:0] mac, logic [31:0] ip,
                                     int slot, int held);
        t_out_word r;
        r.kind = k; r.peer_mac = mac; r.peer_ip = ip;
        r.slot = slot[3:0]; r.held_count = held[10:0]; r.last = 1'b0;
        return r;
    endfunction

    // Works out the results of one word and advances the shadow cache
    task automatic resolve_arp_item(input t_in_word w, output t_out_word res[$]);
        int s;
        res = {};
        case (t_cmd'(w.cmd))
            CMD_ARP: begin
                if (w.target_ip == cfg_ip) begin
                    s = claim_entry(w.sender_ip);
                    if (s >= 0) begin
                        ent_mac[s] = w.sender_mac; ent_ok[s] = 1; ent_stamp[s] = now_ticks;
                    end
                    if (w.oper == 16'd1)
                        res.push_back(mk(K_REPLY, w.sender_mac, w.sender_ip,
                                         s >= 0 ? s : 0, 0));
                end
            end
            CMD_RESOLVE: begin
                s = find_entry(w.next_hop_ip);
                if (s >= 0 && ent_ok[s]) begin
                    res.push_back(mk(K_FORWARD, ent_mac[s], w.next_hop_ip, s, 0));
                end else begin
                    s = claim_entry(w.next_hop_ip);
                    if (s < 0) begin
                        // table full: drop, no request
                        res.push_back(mk(K_DROPPED, '0, w.next_hop_ip, 0, 0));
                    end else begin
                        ent_ok[s] = 0;
                        if (ent_wait[s] >= PendingLimit) begin
                            res.push_back(mk(K_DROPPED, '0, w.next_hop_ip, s, ent_wait[s]));
                        end else begin
                            ent_wait[s]++;
                            res.push_back(mk(K_HELD, '0, w.next_hop_ip, s, ent_wait[s]));
                        end
                        res.push_back(mk(K_REQUEST, BcastMac, w.next_hop_ip, s, 0));
                    end
                end
            end
            CMD_TICK: now_ticks = now_ticks + 32'd1;
            default: begin
                for (int i = 0; i < TableEntries; i++) begin
                    if (!ent_used[i]) continue;
                    if (ent_ok[i]) begin
                        if (ent_wait[i] != 0) begin
                            res.push_back(mk(K_RELEASE, ent_mac[i], ent_ip[i], i, ent_wait[i]));
                            ent_wait[i] = 0;
                        end
                        // aged out: freed, and no request for it
                        if (now_ticks - ent_stamp[i] > cfg_age) begin
                            ent_used[i] = 0; ent_ok[i] = 0; ent_wait[i] = 0;
                            continue;
                        end
                    end
                    res.push_back(mk(K_REQUEST, BcastMac, ent_ip[i], i, 0));
                end
            end
        endcase
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
    endtask

    // Sends one word; valid stays up afterwards unless the next word idles first
    task automatic send_word(input t_in_word w, input bit use_typed, input t_out_word typed);
        t_out_word res[$];
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        resolve_arp_item(w, res);
        if (use_typed) begin
            typed.last = 1'b1;
            due_words.push_back(typed);
        end else begin
            foreach (res[k]) due_words.push_back(res[k]);
        end
    endtask

    task automatic send_plain(input t_in_word w);
        send_word(w, 1'b0, '0);
    endtask

    // Drops valid and waits until every owed result is back, plus a margin
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LOCAL_IP:  cfg_ip  = val[31:0];
            CFG_LOCAL_MAC: ;
            default:       cfg_age = val[31:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        int pick;
        w.oper        = 16'($urandom);
        w.sender_ip   = $urandom;
        w.sender_mac  = {16'($urandom), 32'($urandom)};
        w.target_ip   = $urandom;
        w.next_hop_ip = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            w.cmd = CMD_ARP;
            if ($urandom_range(0, 99) < 85) w.target_ip = cfg_ip;
            pick = $urandom_range(0, 99);
            if (pick < 45) w.oper = 16'd1;
            else if (pick < 80) w.oper = 16'd2;
            if ($urandom_range(0, 9) != 0) w.sender_ip = ip_pool[$urandom_range(0, 23)];
        end else if (pick < 75) begin
            w.cmd = CMD_RESOLVE;
            if ($urandom_range(0, 9) != 0) w.next_hop_ip = ip_pool[$urandom_range(0, 23)];
        end else if (pick < 92) begin
            w.cmd = CMD_TICK;
        end else begin
            w.cmd = CMD_SCAN;
        end
        return w;
    endfunction

    task automatic run_random(input int count, input int calm_from, input int calm_to);
        for (int n = 0; n < count; n++) begin
            quiet = (n >= calm_from && n < calm_to);
            send_plain(rand_word());
        end
        quiet = 0;
    endtask

    // Receiver: random stalls, plus one long hold-off counted here
    int hold_left = 0;
    bit hold_seen = 0;
    always @(negedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_left = HoldOffCycles;
            hold_seen = 1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 23);
        end
    end

    task automatic field_err(input string name, input logic [63:0] e, input logic [63:0] a);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
        err_cnt++;
    endtask

    // Result checker and stall watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, o_out_data);
                    err_cnt++;
                end else begin
                    e = due_words.pop_front();
                    if (o_out_data.kind != e.kind)
                        field_err("kind", 64'(e.kind), 64'(o_out_data.kind));
                    if (o_out_data.peer_mac != e.peer_mac)
                        field_err("peer_mac", 64'(e.peer_mac), 64'(o_out_data.peer_mac));
                    if (o_out_data.peer_ip != e.peer_ip)
                        field_err("peer_ip", 64'(e.peer_ip), 64'(o_out_data.peer_ip));
                    if (o_out_data.slot != e.slot)
                        field_err("slot", 64'(e.slot), 64'(o_out_data.slot));
                    if (o_out_data.held_count != e.held_count)
                        field_err("held_count", 64'(e.held_count),
                                  64'(o_out_data.held_count));
                    if (o_out_data.last != e.last)
                        field_err("last", 64'(e.last), 64'(o_out_data.last));
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Directed rows: typed expectation only where it is obvious
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word exp;
    } t_row;

    localparam logic [31:0] LocalIp = 32'hC0A8_0001;
    localparam logic [47:0] LocalMac = 48'h02AA_BBCC_DDEE;
    localparam logic [31:0] PeerA = 32'h0A00_0005;
    localparam logic [31:0] PeerB = 32'h0A00_0006;
    localparam logic [31:0] PeerC = 32'h0A00_0007;
    localparam logic [31:0] FloodIp = 32'h7F00_00AB;

    function automatic t_row row(t_cmd c, logic [15:0] op, logic [31:0] sip, logic [47:0] smac,
                                 logic [31:0] tip, logic [31:0] nh);
        t_row r;
        r.w = '{cmd: c, oper: op, sender_ip: sip, sender_mac: smac,
                target_ip: tip, next_hop_ip: nh};
        r.typed = 0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, t_kind k, logic [47:0] mac, logic [31:0] ip,
                                       int slot);
        r.typed = 1;
        r.exp = mk(k, mac, ip, slot, 0);
        return r;
    endfunction

    initial begin
        t_row tbl[$];
        t_in_word w;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_LOCAL_IP; i_cfg_data = '0;
        quiet = 0; hold_req = 0;
        cfg_ip = '0; cfg_age = 32'd5000; now_ticks = '0;
        for (int i = 0; i < TableEntries; i++) begin
            ent_ok[i] = 0; ent_used[i] = 0; ent_wait[i] = 0;
            ent_ip[i] = '0; ent_mac[i] = '0; ent_stamp[i] = '0;
        end
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0; ip_pool[1] = 32'hFFFF_FFFF;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_LOCAL_IP, {16'h0, LocalIp});
        write_reg(CFG_LOCAL_MAC, LocalMac);
        write_reg(CFG_AGE_LIMIT, 48'd5000);

        // Empty table, ignored packet, learning at address extremes, odd opcodes
        tbl.push_back(row(CMD_TICK, '0, '0, '0, '0, '0));
        tbl.push_back(row(CMD_SCAN, '0, '0, '0, '0, '0));
        tbl.push_back(row(CMD_ARP, 16'd1, PeerA, 48'h1, ~LocalIp, '0));
        tbl.push_back(typed_row(row(CMD_ARP, 16'd1, 32'h0, 48'h0, LocalIp, '1),
                                K_REPLY, 48'h0, 32'h0, 0));
        tbl.push_back(typed_row(row(CMD_ARP, 16'd1, '1, '1, LocalIp, '0),
                                K_REPLY, '1, '1, 1));
        tbl.push_back(row(CMD_ARP, 16'd2, PeerA, 48'h0000_1111_2222, LocalIp, '0));
        tbl.push_back(row(CMD_ARP, 16'hFFFF, PeerB, 48'hA5A5_5A5A_0F0F, LocalIp, '0));
        tbl.push_back(row(CMD_ARP, 16'd0, PeerB, 48'hA5A5_5A5A_0F0E, LocalIp, '0));
        tbl.push_back(typed_row(row(CMD_RESOLVE, '1, '1, '1, '1, 32'h0),
                                K_FORWARD, 48'h0, 32'h0, 0));
        tbl.push_back(typed_row(row(CMD_RESOLVE, '0, '0, '0, '0, '1),
                                K_FORWARD, '1, '1, 1));
        // Unknown next hop: held plus broadcast request, then learned and released
        tbl.push_back(row(CMD_RESOLVE, '0, '0, '0, '0, PeerC));
        tbl.push_back(row(CMD_RESOLVE, '0, '0, '0, '0, PeerC));
        tbl.push_back(row(CMD_SCAN, '0, '0, '0, '0, '0));
        tbl.push_back(row(CMD_ARP, 16'd2, PeerC, 48'hFEDC_BA98_7654, LocalIp, '0));
        tbl.push_back(row(CMD_RESOLVE, '0, '0, '0, '0, PeerC));
        tbl.push_back(row(CMD_SCAN, '0, '0, '0, '0, '0));
        tbl.push_back(row(CMD_TICK, '1, '1, '1, '1, '1));
        tbl.push_back(row(CMD_RESOLVE, '0, '0, '0, '0, PeerB));
        foreach (tbl[i]) send_word(tbl[i].w, tbl[i].typed, tbl[i].exp);
        drain();

        run_random(140, 40, 70);
        drain();

        // Short age limit, all-ones addresses; receiver holds off early
        write_reg(CFG_AGE_LIMIT, 48'd1);
        write_reg(CFG_LOCAL_IP, 48'hFFFF_FFFF);
        write_reg(CFG_LOCAL_MAC, '1);
        hold_req = 1;
        run_random(130, 90, 130);
        drain();

        write_reg(CFG_AGE_LIMIT, 48'hFFFF_FFFF);
        write_reg(CFG_LOCAL_IP, 48'h0);
        write_reg(CFG_LOCAL_MAC, 48'h0);
        run_random(120, 0, 50);
        drain();

        // Empty the table: learn every entry, age them out, then pile up
        // pending packets on one hop and release the lot
        write_reg(CFG_AGE_LIMIT, 48'd1);
        for (int i = 0; i < TableEntries; i++) begin
            if (ent_used[i])
                send_plain('{cmd: CMD_ARP, oper: 16'd2, sender_ip: ent_ip[i],
                             sender_mac: 48'h1234, target_ip: cfg_ip, next_hop_ip: '0});
        end
        w = '{cmd: CMD_TICK, oper: '0, sender_ip: '0, sender_mac: '0,
              target_ip: '0, next_hop_ip: FloodIp};
        repeat (3) send_plain(w);
        w.cmd = CMD_SCAN;
        send_plain(w);
        w.cmd = CMD_RESOLVE;
        repeat (FloodCount) send_plain(w);
        send_plain('{cmd: CMD_ARP, oper: 16'd1, sender_ip: FloodIp,
                     sender_mac: 48'hCAFE_0000_BEEF, target_ip: cfg_ip, next_hop_ip: '0});
        w.cmd = CMD_SCAN;
        send_plain(w);
        drain();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
